// ===== sv/crs_pkg.sv =====
// Shared widths, constants, sequencer states and step-unit result type for the Collatz range search.
package crs_pkg;

	localparam int START_BITS  = 16;
	localparam int VALUE_BITS  = 48;
	localparam int LENGTH_BITS = 10;

	localparam logic [VALUE_BITS-1:0]  VALUE_MAX  = {VALUE_BITS{1'b1}};
	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
	// largest value whose 3v+1 still fits
	localparam logic [VALUE_BITS-1:0]  STEP_LIMIT = (VALUE_MAX - 1) / 3;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_RUN    = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	typedef struct packed {
		logic                   is_one;
		logic                   abandon;
		logic                   len_ovf;
		logic [VALUE_BITS-1:0]  next_value;
		logic [VALUE_BITS-1:0]  next_peak;
		logic [LENGTH_BITS-1:0] next_term;
	} step_res_t;

endpackage

// ===== sv/collatz_range_search_core.sv =====
// Top level of the Collatz range search: sequencer, best trackers and result register.
// Flow: after accept, RUN takes one step per sequence term over every k in 1..n, then FINISH
// loads the result once the result register is free; a zero limit goes straight to FINISH.
// Throughput: one item at a time; in_stall is high from accept until the result is loaded.
// One shared 48-bit 3v+1/halve unit sets the pace.
// Reset (arst_n low, asynchronous): sequencer idle, no result pending.
module collatz_range_search_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [crs_pkg::START_BITS-1:0]    search_limit,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [crs_pkg::LENGTH_BITS-1:0]   longest_length,
	output logic [crs_pkg::START_BITS-1:0]    longest_start,
	output logic [crs_pkg::VALUE_BITS-1:0]    highest_peak,
	output logic [crs_pkg::START_BITS-1:0]    peak_start,
	output logic                              bad_limit,
	output logic                              overflowed
);
	import crs_pkg::*;

	state_t state_q;

	// working registers of the current sequence
	logic [START_BITS-1:0]  limit_q;
	logic [START_BITS-1:0]  k_q;
	logic [VALUE_BITS-1:0]  value_q;
	logic [VALUE_BITS-1:0]  peak_q;
	logic [LENGTH_BITS-1:0] term_q;

	// running bests over the range
	logic [LENGTH_BITS-1:0] best_len_q;
	logic [START_BITS-1:0]  best_len_start_q;
	logic [VALUE_BITS-1:0]  best_peak_q;
	logic [START_BITS-1:0]  best_peak_start_q;
	logic                   ovf_q;
	logic                   bad_q;

	step_res_t              step;

	// end-of-sequence candidates
	logic                   seq_end;
	logic [LENGTH_BITS-1:0] cand_len;
	logic [VALUE_BITS-1:0]  cand_peak;
	logic [START_BITS-1:0]  k_next;
	logic                   in_take;
	logic                   out_free;

	crs_step_unit u_step (
		.value (value_q),
		.peak  (peak_q),
		.term  (term_q),
		.res   (step)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && !in_stall;
	// result register may be loaded when empty or being taken this edge
	assign out_free = !out_valid || !out_stall;

	// a sequence ends when it reaches 1, or is abandoned on value overflow
	// (then the abandoned step's term counts and the peak saturates)
	assign seq_end   = step.is_one || step.abandon;
	assign cand_len  = step.is_one ? term_q : step.next_term;
	assign cand_peak = step.is_one ? peak_q : VALUE_MAX;
	assign k_next    = k_q + {{(START_BITS-1){1'b0}}, 1'b1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						state_q <= (search_limit == '0) ? ST_FINISH : ST_RUN;
					end
				end
				ST_RUN: begin
					if (seq_end && (k_q == limit_q)) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: load on accept, one step per cycle in RUN
	always_ff @(posedge clk) begin
		if (in_take) begin
			limit_q           <= search_limit;
			bad_q             <= (search_limit == '0);
			k_q               <= {{(START_BITS-1){1'b0}}, 1'b1};
			value_q           <= {{(VALUE_BITS-1){1'b0}}, 1'b1};
			peak_q            <= {{(VALUE_BITS-1){1'b0}}, 1'b1};
			term_q            <= {{(LENGTH_BITS-1){1'b0}}, 1'b1};
			best_len_q        <= '0;
			best_len_start_q  <= '0;
			best_peak_q       <= '0;
			best_peak_start_q <= '0;
			ovf_q             <= 1'b0;
		end else if (state_q == ST_RUN) begin
			if (seq_end) begin
				// strict compare: smallest k wins ties
				if (cand_len > best_len_q) begin
					best_len_q       <= cand_len;
					best_len_start_q <= k_q;
				end
				if (cand_peak > best_peak_q) begin
					best_peak_q       <= cand_peak;
					best_peak_start_q <= k_q;
				end
				if (step.abandon) begin
					ovf_q <= 1'b1;
				end
				// next start; unused after the last one
				k_q     <= k_next;
				value_q <= {{(VALUE_BITS-START_BITS){1'b0}}, k_next};
				peak_q  <= {{(VALUE_BITS-START_BITS){1'b0}}, k_next};
				term_q  <= {{(LENGTH_BITS-1){1'b0}}, 1'b1};
			end else begin
				value_q <= step.next_value;
				peak_q  <= step.next_peak;
				term_q  <= step.next_term;
				if (step.len_ovf) begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	// result register: holds one item so the next search can start meanwhile
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (state_q == ST_FINISH && out_free) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && out_free) begin
			longest_length <= best_len_q;
			longest_start  <= best_len_start_q;
			highest_peak   <= best_peak_q;
			peak_start     <= best_peak_start_q;
			bad_limit      <= bad_q;
			overflowed     <= ovf_q;
		end
	end

	// a rejected limit carries all-zero results
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_limit |-> longest_length == '0 && highest_peak == '0 &&
			longest_start == '0 && peak_start == '0 && !overflowed)
		else $error("bad limit result carries nonzero fields");

	// any accepted nonzero limit has at least one term
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_limit |-> longest_length != '0)
		else $error("valid search result with zero length");

	// the running peak never falls below the current value
	a_peak_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> peak_q >= value_q)
		else $error("sequence peak below current value");

	// recorded best start never runs ahead of the start being examined
	a_best_start: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> best_len_start_q <= k_q && best_peak_start_q <= k_q &&
			k_q <= limit_q)
		else $error("best start beyond current start");

endmodule

// ===== sv/crs_step_unit.sv =====
// Shared Collatz step unit: one halve or 3v+1 step with peak tracking and saturating term count.
module crs_step_unit (
	input  logic [crs_pkg::VALUE_BITS-1:0]  value,
	input  logic [crs_pkg::VALUE_BITS-1:0]  peak,
	input  logic [crs_pkg::LENGTH_BITS-1:0] term,
	output crs_pkg::step_res_t              res
);
	import crs_pkg::*;

	logic                  odd;
	logic [VALUE_BITS-1:0] tripled;
	logic [VALUE_BITS-1:0] stepped;

	assign odd     = value[0];
	assign tripled = {value[VALUE_BITS-2:0], 1'b0} + value + {{(VALUE_BITS-1){1'b0}}, 1'b1};
	assign stepped = odd ? tripled : {1'b0, value[VALUE_BITS-1:1]};

	always_comb begin
		res.is_one     = (value == {{(VALUE_BITS-1){1'b0}}, 1'b1});
		res.abandon    = odd && (value > STEP_LIMIT);
		res.len_ovf    = (term == LENGTH_MAX);
		res.next_value = stepped;
		res.next_term  = res.len_ovf ? term : term + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
		if (res.abandon) begin
			res.next_peak = VALUE_MAX;
		end else if (stepped > peak) begin
			res.next_peak = stepped;
		end else begin
			res.next_peak = peak;
		end
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the Collatz range search core with a built-in search predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import crs_pkg::*;

	// One result item, laid out field by field as the core presents it.
	typedef struct {
		logic [LENGTH_BITS-1:0] longest_length;
		logic [START_BITS-1:0]  longest_start;
		logic [VALUE_BITS-1:0]  highest_peak;
		logic [START_BITS-1:0]  peak_start;
		logic                   bad_limit;
		logic                   overflowed;
	} search_result_t;

	logic                   clk          = 1'b0;
	logic                   arst_n       = 1'b0;
	logic                   in_valid     = 1'b0;
	logic                   in_stall;
	logic [START_BITS-1:0]  search_limit = '0;
	logic                   out_valid;
	logic                   out_stall    = 1'b0;
	logic [LENGTH_BITS-1:0] longest_length;
	logic [START_BITS-1:0]  longest_start;
	logic [VALUE_BITS-1:0]  highest_peak;
	logic [START_BITS-1:0]  peak_start;
	logic                   bad_limit;
	logic                   overflowed;

	logic [START_BITS-1:0] limits_to_send[$];      // items not yet offered to the core
	search_result_t        expected_results[$];    // one per accepted limit, oldest first

	int unsigned     items_total    = 0;
	int unsigned     items_accepted = 0;
	int unsigned     error_count    = 0;
	int unsigned     gap_left       = 0;
	int unsigned     stall_left     = 0;
	longint unsigned sum_of_terms   = 0;
	longint unsigned cycle_count    = 0;
	// Grows with every accepted item by a multiple of the work that item needs;
	// the base covers sender gaps and the reset period.
	longint unsigned cycle_budget   = 200_000;

	collatz_range_search_core u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.search_limit   (search_limit),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.longest_length (longest_length),
		.longest_start  (longest_start),
		.highest_peak   (highest_peak),
		.peak_start     (peak_start),
		.bad_limit      (bad_limit),
		.overflowed     (overflowed)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Run every start 1..limit through the 3v+1 iteration and track the longest
	// sequence and the highest value, smallest start winning ties (strict compare).
	// Also returns the total term count, which sets the watchdog budget.
	function automatic search_result_t search_range(input logic [START_BITS-1:0] limit,
	                                                output longint unsigned terms);
		search_result_t         res;
		logic [VALUE_BITS-1:0]  v;
		logic [VALUE_BITS-1:0]  peak;
		logic [LENGTH_BITS-1:0] count;
		logic                   abandoned;
		res = '{default: '0};
		terms = 0;
		v = '0;
		if (limit == '0) begin
			// zero limit: flag only, every other field zero
			res.bad_limit = 1'b1;
			return res;
		end
		for (longint unsigned k = 1; k <= limit; k++) begin
			count = 1;
			abandoned = 1'b0;
			if (k > 64'(VALUE_MAX)) begin
				// start itself does not fit the value width
				peak = VALUE_MAX;
				abandoned = 1'b1;
				res.overflowed = 1'b1;
			end else begin
				v = VALUE_BITS'(k);
				peak = v;
			end
			while (!abandoned && v != 1) begin
				if (!v[0]) begin
					v = v >> 1;
				end else if (v > STEP_LIMIT) begin
					// 3v+1 would not fit: saturate the peak and drop this start,
					// the saturated term still counts
					peak = VALUE_MAX;
					abandoned = 1'b1;
					res.overflowed = 1'b1;
				end else begin
					v = v * 3 + 1;
				end
				// term count saturates but the iteration keeps going
				if (count != LENGTH_MAX)
					count++;
				else
					res.overflowed = 1'b1;
				if (!abandoned && v > peak)
					peak = v;
			end
			if (count > res.longest_length) begin
				res.longest_length = count;
				res.longest_start  = START_BITS'(k);
			end
			if (peak > res.highest_peak) begin
				res.highest_peak = peak;
				res.peak_start   = START_BITS'(k);
			end
			terms += count;
		end
		return res;
	endfunction

	// Idle length for both sides: mostly none or short, now and then long.
	function automatic int unsigned gap_cycles();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 60);
	endfunction

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	// Append helpers for the two queues.
	task automatic add_limit(input logic [START_BITS-1:0] lim);
		limits_to_send = {limits_to_send, lim};
	endtask

	task automatic add_expected(input search_result_t item);
		expected_results = {expected_results, item};
	endtask

	// Stimulus: directed limits first, then random ones.
	// With 48-bit values and 10-bit lengths no start below 2^16 can overflow,
	// so the saturation paths live only in the predictor here.
	initial begin
		int unsigned directed_limits [19];
		int unsigned pick;
		logic [START_BITS-1:0] lim;

		directed_limits = '{
			0,      // zero limit rejected
			1,      // single start, sequence of one term
			2, 3, 4,
			7,      // peak 52
			9,      // 9 also peaks at 52: smaller start keeps the peak
			0,      // zero limit again right after a real search
			18,     // 18 gives 21 terms
			19,     // 19 also gives 21 terms: tie on length
			27,     // long climb to 9232
			97, 255, 256, 511, 871, 1023, 4095,
			65535   // every limit bit high, full range
		};
		foreach (directed_limits[i])
			add_limit(START_BITS'(directed_limits[i]));
		// Random part: mostly small ranges keep the run short, a few wider ones.
		repeat (81) begin
			pick = $urandom_range(0, 99);
			if (pick < 8)
				lim = '0;
			else if (pick < 65)
				lim = START_BITS'($urandom_range(1, 200));
			else if (pick < 93)
				lim = START_BITS'($urandom_range(201, 1500));
			else
				lim = START_BITS'($urandom_range(1501, 4095));
			add_limit(lim);
		end
		items_total = limits_to_send.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Drain: everything sent, every result back, then a short settle.
		wait (arst_n && items_accepted == items_total && expected_results.size() == 0);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Driver: predicts on accept, then holds, idles or offers the next limit.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid     <= 1'b0;
			search_limit <= '0;
			gap_left     <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				add_expected(search_range(search_limit, sum_of_terms));
				cycle_budget += 4 * (sum_of_terms + 200);
				items_accepted++;
			end
			// a stalled item stays as it is
			if (!(in_valid && in_stall)) begin
				if (gap_left != 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (limits_to_send.size() != 0) begin
					in_valid     <= 1'b1;
					search_limit <= limits_to_send.pop_front();
					gap_left     <= gap_cycles();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted result against the oldest prediction and
	// throws random stalls of varied length at the result channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					flag_error("result with no item pending");
				end else begin
					search_result_t want;
					want = expected_results.pop_front();
					if (longest_length !== want.longest_length)
						flag_error($sformatf("longest_length %0d, expected %0d",
							longest_length, want.longest_length));
					if (longest_start !== want.longest_start)
						flag_error($sformatf("longest_start %0d, expected %0d",
							longest_start, want.longest_start));
					if (highest_peak !== want.highest_peak)
						flag_error($sformatf("highest_peak %0d, expected %0d",
							highest_peak, want.highest_peak));
					if (peak_start !== want.peak_start)
						flag_error($sformatf("peak_start %0d, expected %0d",
							peak_start, want.peak_start));
					if (bad_limit !== want.bad_limit)
						flag_error($sformatf("bad_limit %0b, expected %0b",
							bad_limit, want.bad_limit));
					if (overflowed !== want.overflowed)
						flag_error($sformatf("overflowed %0b, expected %0b",
							overflowed, want.overflowed));
				end
			end
			if (stall_left != 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if ($urandom_range(0, 7) == 0) begin
				out_stall  <= 1'b1;
				stall_left <= gap_cycles();
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog against a hung core.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > cycle_budget) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule

// ===== sim.f =====
sv/crs_pkg.sv
sv/crs_step_unit.sv
sv/collatz_range_search_core.sv
tb/sv/tb_top.sv
